[rtl/evp_pkg.sv]
// Package for the elliptical vignette pixel block: widths, register indexes
// and shared types. No dependencies.
package evp_pkg;
  localparam int MAX_DIM_DEF = 4096;
  localparam int DIM_W = 13;
  localparam int EXT_W = 14;
  localparam int POS_W = 12;
  localparam int CH_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam int NUM_W = 58;  // sums of two 54-bit products, and h2*w2 (56 bits)
  localparam int QUO_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EW = 2'd3;

  // classification handed from front to back
  typedef enum logic [1:0] {CLS_PASS, CLS_ZERO, CLS_SCALE} cls_t;

  typedef struct packed {
    cls_t cls;
    logic [NUM_W-1:0] numer;  // Nc - Dp
    logic [NUM_W-1:0] denom;  // Nc - Ne
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;
  } job_t;
endpackage

[rtl/evp_front.sv]
// Front part: computes the distance terms over pipelined multiply stages and
// classifies each pixel. Depends on evp_pkg.
module evp_front #(
  parameter int MAX_DIM = evp_pkg::MAX_DIM_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [evp_pkg::POS_W-1:0] row_index,
  input  logic [evp_pkg::POS_W-1:0] col_index,
  input  logic [evp_pkg::CH_W-1:0] channel_0,
  input  logic [evp_pkg::CH_W-1:0] channel_1,
  input  logic [evp_pkg::CH_W-1:0] channel_2,
  input  logic [evp_pkg::DIM_W-1:0] rows_cfg,
  input  logic [evp_pkg::DIM_W-1:0] cols_cfg,
  input  logic [evp_pkg::EXT_W-1:0] eh_cfg,
  input  logic [evp_pkg::EXT_W-1:0] ew_cfg,
  output logic job_valid,
  output evp_pkg::job_t job
);
  import evp_pkg::*;
  localparam int OFF_W = (DIM_W > POS_W + 1 ? DIM_W : POS_W + 1);
  // a limit at or above the register range leaves the dimension as written
  localparam int MAX_CL = (MAX_DIM < (1 << DIM_W)) ? MAX_DIM : (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_CL);

  // stage 1: clamp, offsets, squares of narrow terms
  logic v1, v2, v3, v4;
  logic [DIM_W-1:0] r_cl, c_cl;
  logic [OFF_W-1:0] dr, dc, twr, twc;
  logic [2*OFF_W-1:0] dr2, dc2;
  logic [2*DIM_W-1:0] r2, c2;
  logic [2*EXT_W-1:0] h2, w2;
  logic [3*CH_W-1:0] px1, px2, px3;

  always_comb begin
    r_cl = (rows_cfg > MAXD) ? MAXD : rows_cfg;
    c_cl = (cols_cfg > MAXD) ? MAXD : cols_cfg;
    twr = OFF_W'({row_index, 1'b0});
    twc = OFF_W'({col_index, 1'b0});
    dr = (twr >= OFF_W'(r_cl)) ? twr - OFF_W'(r_cl) : OFF_W'(r_cl) - twr;
    dc = (twc >= OFF_W'(c_cl)) ? twc - OFF_W'(c_cl) : OFF_W'(c_cl) - twc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
    dr2 <= dr * dr;
    dc2 <= dc * dc;
    r2 <= r_cl * r_cl;
    c2 <= c_cl * c_cl;
    h2 <= eh_cfg * eh_cfg;
    w2 <= ew_cfg * ew_cfg;
    px1 <= {channel_2, channel_1, channel_0};
  end

  // stage 2: products with ellipse squares (each 28x28 or narrower)
  logic [NUM_W-1:0] pr_w, pc_h, nr_w, nc_h, ne;
  always_ff @(posedge clk) begin
    pr_w <= NUM_W'(dr2 * w2);
    pc_h <= NUM_W'(dc2 * h2);
    nr_w <= NUM_W'(r2 * w2);
    nc_h <= NUM_W'(c2 * h2);
    ne <= NUM_W'(h2 * w2);
    px2 <= px1;
  end

  // stage 3: sums
  logic [NUM_W-1:0] dp, nc, ne3;
  always_ff @(posedge clk) begin
    dp <= pr_w + pc_h;
    nc <= nr_w + nc_h;
    ne3 <= ne;
    px3 <= px2;
  end

  // stage 4: classify
  always_ff @(posedge clk) begin
    if (dp <= ne3) job.cls <= CLS_PASS;
    else if (dp >= nc) job.cls <= CLS_ZERO;
    else job.cls <= CLS_SCALE;
    job.numer <= nc - dp;
    job.denom <= nc - ne3;
    {job.ch2, job.ch1, job.ch0} <= px3;
  end
  assign job_valid = v4;
endmodule

[rtl/evp_fifo.sv]
// Short queue between front and back parts. Depends on evp_pkg.
module evp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  evp_pkg::job_t wr_data,
  input  logic rd_en,
  output logic not_empty,
  output logic rd_valid,
  output evp_pkg::job_t rd_data
);
  import evp_pkg::*;
  localparam int AW = $clog2(DEPTH);
  job_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) wp <= AW'((wp + 1'b1) % DEPTH);
      if (rd_en) rp <= AW'((rp + 1'b1) % DEPTH);
      cnt <= cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
      rd_valid <= rd_en;
    end
    if (wr_en) mem[wp] <= wr_data;
    if (rd_en) rd_data <= mem[rp];
  end
  assign not_empty = (cnt != '0);
endmodule

[rtl/evp_back.sv]
// Back part: three pipelined restoring dividers, one quotient bit a stage.
// Depends on evp_pkg.
module evp_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  evp_pkg::job_t job,
  output logic done,
  output logic [evp_pkg::CH_W-1:0] q0,
  output logic [evp_pkg::CH_W-1:0] q1,
  output logic [evp_pkg::CH_W-1:0] q2
);
  import evp_pkg::*;
  localparam int PW = NUM_W + CH_W;  // p * numer
  localparam int S = QUO_W;

  // stage 0: products p*numer
  logic v0;
  cls_t cls0;
  logic [PW-1:0] prod0 [3];
  logic [NUM_W-1:0] den0;
  logic [CH_W-1:0] pix0 [3];
  always_ff @(posedge clk) begin
    v0 <= rst ? 1'b0 : job_valid;
    cls0 <= job.cls;
    den0 <= job.denom;
    prod0[0] <= PW'(job.numer * job.ch0);
    prod0[1] <= PW'(job.numer * job.ch1);
    prod0[2] <= PW'(job.numer * job.ch2);
    pix0[0] <= job.ch0; pix0[1] <= job.ch1; pix0[2] <= job.ch2;
  end

  // quotient < 256 since numer < denom; stage i sets bit k = S-1-i by testing den<<k
  logic vs [S+1];
  cls_t cs [S+1];
  logic [NUM_W-1:0] ds [S+1];
  logic [PW-1:0] rem [S+1][3];
  logic [QUO_W-1:0] qs [S+1][3];
  logic [CH_W-1:0] ps [S+1][3];

  always_comb begin
    vs[0] = v0; cs[0] = cls0; ds[0] = den0;
    for (int k = 0; k < 3; k++) begin
      rem[0][k] = prod0[k]; qs[0][k] = '0; ps[0][k] = pix0[k];
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_div
    localparam int SH = S - 1 - i;
    always_ff @(posedge clk) begin
      vs[i+1] <= rst ? 1'b0 : vs[i];
      cs[i+1] <= cs[i];
      ds[i+1] <= ds[i];
      for (int k = 0; k < 3; k++) begin
        ps[i+1][k] <= ps[i][k];
        if (rem[i][k] >= (PW'(ds[i]) << SH)) begin
          rem[i+1][k] <= rem[i][k] - (PW'(ds[i]) << SH);
          qs[i+1][k] <= qs[i][k] | QUO_W'(1 << SH);
        end else begin
          rem[i+1][k] <= rem[i][k];
          qs[i+1][k] <= qs[i][k];
        end
      end
    end
  end

  logic [CH_W-1:0] sel [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (cs[S])
        CLS_PASS: sel[k] = ps[S][k];
        CLS_ZERO: sel[k] = '0;
        default:  sel[k] = qs[S][k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : vs[S];
    q0 <= sel[0]; q1 <= sel[1]; q2 <= sel[2];
  end
endmodule

[rtl/elliptical_vignette_pixel.sv]
// Elliptical vignette, one pixel per clock.
// Throughput: one pixel every cycle; start may stay high continuously.
// Path from accept to done: 4 front stages, queue write,
// registered queue read, 1 product stage, 8 divider stages, output register.
// Reset (rst, synchronous): registers take 1080/1920/1080/1920, pipe empties.
// Results are strobed by done for one cycle; the receiver cannot stall.
module elliptical_vignette_pixel #(
  parameter int MAX_DIM = evp_pkg::MAX_DIM_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [evp_pkg::POS_W-1:0] row_index,
  input  logic [evp_pkg::POS_W-1:0] col_index,
  input  logic [evp_pkg::CH_W-1:0] channel_0,
  input  logic [evp_pkg::CH_W-1:0] channel_1,
  input  logic [evp_pkg::CH_W-1:0] channel_2,
  input  logic cfg_we,
  input  logic [evp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [evp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic done,
  output logic [evp_pkg::CH_W-1:0] out_channel_0,
  output logic [evp_pkg::CH_W-1:0] out_channel_1,
  output logic [evp_pkg::CH_W-1:0] out_channel_2
);
  import evp_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] image_rows, image_cols;
  logic [EXT_W-1:0] ellipse_height, ellipse_width;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= DIM_W'(1080);
      image_cols <= DIM_W'(1920);
      ellipse_height <= EXT_W'(1080);
      ellipse_width <= EXT_W'(1920);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: image_rows <= cfg_data[DIM_W-1:0];
        REG_COLS: image_cols <= cfg_data[DIM_W-1:0];
        REG_EH:   ellipse_height <= cfg_data;
        REG_EW:   ellipse_width <= cfg_data;
        default:  ;
      endcase
    end
  end

  // the back part never stalls, so the pipe is always ready
  assign busy = 1'b0;

  logic f_valid;
  job_t f_job;
  evp_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk, .rst, .in_valid(start & ~busy),
    .row_index, .col_index, .channel_0, .channel_1, .channel_2,
    .rows_cfg(image_rows), .cols_cfg(image_cols),
    .eh_cfg(ellipse_height), .ew_cfg(ellipse_width),
    .job_valid(f_valid), .job(f_job)
  );

  // queue drains one job a cycle whenever non-empty; its read is registered
  logic q_ne;
  logic b_valid;
  job_t b_job;
  evp_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst, .wr_en(f_valid), .wr_data(f_job),
    .rd_en(q_ne), .not_empty(q_ne), .rd_valid(b_valid), .rd_data(b_job)
  );

  evp_back u_back (
    .clk, .rst, .job_valid(b_valid), .job(b_job),
    .done, .q0(out_channel_0), .q1(out_channel_1), .q2(out_channel_2)
  );
endmodule

[tb/sv/tb.sv]
// Testbench for elliptical_vignette_pixel: directed word table, then random
// pixels under several register settings, checked against typed values or a local predictor.
// Depends on rtl/evp_pkg.sv and rtl/elliptical_vignette_pixel.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import evp_pkg::*;

  localparam int LAT_WAIT = 30;      // extra wait after the expected-output queue empties
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [CH_W-1:0] c0;
    logic [CH_W-1:0] c1;
    logic [CH_W-1:0] c2;
  } pix_t;

  typedef struct {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    pix_t px;
    bit typed;   // expected value typed in below
    pix_t want;
  } vec_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [POS_W-1:0] row_index = '0;
  logic [POS_W-1:0] col_index = '0;
  logic [CH_W-1:0] channel_0 = '0;
  logic [CH_W-1:0] channel_1 = '0;
  logic [CH_W-1:0] channel_2 = '0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [CH_W-1:0] out_channel_0, out_channel_1, out_channel_2;

  elliptical_vignette_pixel dut (.*);

  always #10 clk = ~clk;

  // predictor copy of the four registers
  logic [DIM_W-1:0] img_rows = 13'd1080;
  logic [DIM_W-1:0] img_cols = 13'd1920;
  logic [EXT_W-1:0] ell_h = 14'd1080;
  logic [EXT_W-1:0] ell_w = 14'd1920;

  pix_t pending_pix[$];   // expected outputs, oldest first
  pix_t typed_pix[$];     // typed expectations waiting to be queued at accept
  bit   typed_flag[$];
  bit   failed = 0;
  int   idle_pct = 0;
  int   cycles = 0;

  // Exact rational vignette: floor(p*(Nc-Dp)/(Nc-Ne)) outside the ellipse.
  function automatic pix_t vignette(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                    pix_t px);
    bit [127:0] r, c, h2, w2, dr, dc, dp, ne, nc, tr, tc;
    bit [127:0] p[3];
    bit [127:0] q[3];
    pix_t res;
    r = (img_rows > MAX_DIM_DEF) ? MAX_DIM_DEF : img_rows;
    c = (img_cols > MAX_DIM_DEF) ? MAX_DIM_DEF : img_cols;
    h2 = ell_h * ell_h;
    w2 = ell_w * ell_w;
    tr = 2 * row;
    tc = 2 * col;
    dr = (tr >= r) ? tr - r : r - tr;
    dc = (tc >= c) ? tc - c : c - tc;
    dp = dr * dr * w2 + dc * dc * h2;
    ne = h2 * w2;
    nc = r * r * w2 + c * c * h2;
    p[0] = px.c0; p[1] = px.c1; p[2] = px.c2;
    for (int k = 0; k < 3; k++) begin
      if (dp <= ne) q[k] = p[k];
      else if (dp >= nc) q[k] = 0;
      else q[k] = (p[k] * (nc - dp)) / (nc - ne);
    end
    res.c0 = q[0][7:0];
    res.c1 = q[1][7:0];
    res.c2 = q[2][7:0];
    return res;
  endfunction

  // Accept and check at the same edge the block sees them.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pix_t px;
      px.c0 = channel_0; px.c1 = channel_1; px.c2 = channel_2;
      if (typed_flag.size() && typed_flag[0])
        pending_pix.push_back(typed_pix[0]);
      else
        pending_pix.push_back(vignette(row_index, col_index, px));
      if (typed_flag.size()) begin
        void'(typed_flag.pop_front());
        void'(typed_pix.pop_front());
      end
    end
    if (!rst && done) begin
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected word %0d %0d %0d", $time,
                 out_channel_0, out_channel_1, out_channel_2);
        failed = 1;
      end else begin
        pix_t w;
        w = pending_pix.pop_front();
        if (out_channel_0 !== w.c0) begin
          $display("%0t: out_channel_0 expected %0d got %0d", $time, w.c0, out_channel_0);
          failed = 1;
        end
        if (out_channel_1 !== w.c1) begin
          $display("%0t: out_channel_1 expected %0d got %0d", $time, w.c1, out_channel_1);
          failed = 1;
        end
        if (out_channel_2 !== w.c2) begin
          $display("%0t: out_channel_2 expected %0d got %0d", $time, w.c2, out_channel_2);
          failed = 1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("elliptical_vignette_pixel regression: fail");
      $finish;
    end
  end

  // Drive one word; start stays high across back-to-back words.
  task automatic send_pixel(logic [POS_W-1:0] row, logic [POS_W-1:0] col, pix_t px,
                            bit typed, pix_t want);
    typed_flag.push_back(typed);
    typed_pix.push_back(want);
    start <= 1;
    row_index <= row;
    col_index <= col;
    channel_0 <= px.c0;
    channel_1 <= px.c1;
    channel_2 <= px.c2;
    do @(posedge clk); while (busy);
    // optional sender gap after the accept
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Register writes only with the pipe drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    start <= 0;
    @(posedge clk);
    while (pending_pix.size()) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_ROWS: img_rows = val[DIM_W-1:0];
      REG_COLS: img_cols = val[DIM_W-1:0];
      REG_EH:   ell_h = val;
      REG_EW:   ell_w = val;
    endcase
  endtask

  function automatic pix_t rand_pix();
    pix_t px;
    int m;
    m = $urandom_range(9);
    px.c0 = (m == 0) ? 8'd0 : (m == 1) ? 8'd255 : 8'($urandom);
    px.c1 = 8'($urandom);
    px.c2 = (m == 2) ? 8'd255 : 8'($urandom);
    return px;
  endfunction

  // pixel positions: mostly inside the image, some anywhere in the field
  function automatic logic [POS_W-1:0] rand_pos(logic [DIM_W-1:0] dim);
    int lim;
    lim = (dim > MAX_DIM_DEF) ? MAX_DIM_DEF : dim;
    if (lim == 0 || $urandom_range(9) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(lim - 1));
  endfunction

  vec_t dir_tab[$];
  pix_t none;

  function automatic vec_t mk(int row, int col, int a, int b, int c, bit typed,
                              int wa, int wb, int wc);
    vec_t v;
    v.row = POS_W'(row); v.col = POS_W'(col);
    v.px.c0 = CH_W'(a); v.px.c1 = CH_W'(b); v.px.c2 = CH_W'(c);
    v.typed = typed;
    v.want.c0 = CH_W'(wa); v.want.c1 = CH_W'(wb); v.want.c2 = CH_W'(wc);
    return v;
  endfunction

  initial begin
    int rows_set[8], cols_set[8], eh_set[8], ew_set[8];
    none = '{default: 0};

    // Reset config: 1080x1920 image, ellipse the same size.
    // Centre passes unchanged; image corner lands exactly on Nc -> zero.
    dir_tab.push_back(mk(540, 960, 255, 255, 255, 1, 255, 255, 255));
    dir_tab.push_back(mk(540, 960, 0, 0, 0, 1, 0, 0, 0));
    dir_tab.push_back(mk(540, 960, 1, 128, 254, 1, 1, 128, 254));
    dir_tab.push_back(mk(0, 0, 255, 255, 255, 1, 0, 0, 0));
    dir_tab.push_back(mk(4095, 4095, 255, 255, 255, 1, 0, 0, 0));
    dir_tab.push_back(mk(4095, 0, 200, 100, 50, 1, 0, 0, 0));
    dir_tab.push_back(mk(0, 4095, 17, 34, 51, 1, 0, 0, 0));
    // scaled region and ellipse edge: predictor
    dir_tab.push_back(mk(0, 960, 255, 255, 255, 0, 0, 0, 0));
    dir_tab.push_back(mk(540, 0, 255, 255, 255, 0, 0, 0, 0));
    dir_tab.push_back(mk(100, 200, 255, 128, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk(1079, 1919, 255, 255, 255, 0, 0, 0, 0));
    dir_tab.push_back(mk(900, 1700, 170, 85, 255, 0, 0, 0, 0));
    dir_tab.push_back(mk(1, 1, 255, 255, 255, 0, 0, 0, 0));
    dir_tab.push_back(mk(2048, 2048, 255, 0, 255, 0, 0, 0, 0));

    // settings: largest (masked/clamped), zero, smallest, 1x1 ellipse, ellipse covering
    // the corner, oversized (clamped) image with zero-height ellipse, 480x640, random
    rows_set = '{16383, 0,    1,  4096, 16,    8191, 480, 0};
    cols_set = '{16383, 0,    1,  4096, 16,    4097, 640, 0};
    eh_set   = '{16383, 0,    1,  1,    16383, 0,    300, 0};
    ew_set   = '{16383, 0,    1,  1,    16383, 5000, 500, 0};
    rows_set[7] = $urandom_range(16383);
    cols_set[7] = $urandom_range(16383);
    eh_set[7] = $urandom_range(16383);
    ew_set[7] = $urandom_range(16383);

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_pixel(dir_tab[i].row, dir_tab[i].col, dir_tab[i].px,
                 dir_tab[i].typed, dir_tab[i].want);

    for (int s = 0; s < 8; s++) begin
      write_reg(REG_ROWS, CFG_DATA_W'(rows_set[s]));
      write_reg(REG_COLS, CFG_DATA_W'(cols_set[s]));
      write_reg(REG_EH, CFG_DATA_W'(eh_set[s]));
      write_reg(REG_EW, CFG_DATA_W'(ew_set[s]));
      // idling phases: none, heavy, none, light
      for (int ph = 0; ph < 4; ph++) begin
        idle_pct = (ph == 1) ? 71 : (ph == 3) ? 32 : 0;
        for (int n = 0; n < 34; n++) begin
          if (ph == 0 && n == 0)  // centre pixel each setting
            send_pixel(POS_W'(((img_rows > 4096) ? 4096 : img_rows) / 2),
                       POS_W'(((img_cols > 4096) ? 4096 : img_cols) / 2),
                       rand_pix(), 0, none);
          else
            send_pixel(rand_pos(img_rows), rand_pos(img_cols), rand_pix(), 0, none);
        end
      end
    end

    start <= 0;
    @(posedge clk);
    while (pending_pix.size()) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
    if (!failed)
      $display("elliptical_vignette_pixel regression: pass");
    else
      $display("elliptical_vignette_pixel regression: fail");
    $finish;
  end
endmodule
